// File: design/bdq_pkg.sv
// bdq_pkg: shared types and constants for the bounded deque block.
// Operation and status codes, controller states, controller command struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

    localparam int DEPTH_DEF = 8;
    localparam int OP_W      = 3;
    localparam int DATA_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int OCC_W     = 4;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_R = 3'd0,
        OP_PUSH_L = 3'd1,
        OP_POP_R  = 3'd2,
        OP_POP_L  = 3'd3,
        OP_PEEK_R = 3'd4,
        OP_PEEK_L = 3'd5,
        OP_DROP_R = 3'd6,
        OP_DROP_L = 3'd7
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_RESP = 2'd2
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;   // capture the accepted item
        logic exec;   // run the operation against the store
    } bdq_cmd_t;

endpackage

`default_nettype wire

// File: design/bdq_ram.sv
// bdq_ram: generic single-port RAM, write or registered read per cycle.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic             re,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: design/bdq_ctrl.sv
// bdq_ctrl: request sequencer for the bounded deque (accept, execute, respond).
// Depends on bdq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdq_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output bdq_pkg::bdq_cmd_t      cmd
);

    bdq_pkg::state_t state_reg;
    bdq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bdq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd        = '0;
        case (state_reg)
            bdq_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = bdq_pkg::S_EXEC;
                end
            end
            bdq_pkg::S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = bdq_pkg::S_RESP;
            end
            bdq_pkg::S_RESP:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = bdq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bdq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/bdq_dpath.sv
// bdq_dpath: head pointer, count, request and result registers, entry store.
// Depends on bdq_pkg and bdq_ram.
`timescale 1ns / 1ps
`default_nettype none

module bdq_dpath #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire bdq_pkg::bdq_cmd_t                   cmd,
    input  wire logic [bdq_pkg::OP_W-1:0]            op,
    input  wire logic signed [bdq_pkg::DATA_W-1:0]   push_value,
    output logic signed [bdq_pkg::DATA_W-1:0]        read_value,
    output logic [bdq_pkg::STATUS_W-1:0]             status,
    output logic [bdq_pkg::OCC_W-1:0]                occupancy
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [IW-1:0] LAST_I  = IW'(DEPTH - 1);

    bdq_pkg::op_t                    op_reg;
    logic [bdq_pkg::DATA_W-1:0]      value_reg;
    logic [IW-1:0]                   head_reg, head_next;
    logic [CW-1:0]                   count_reg, count_next;
    bdq_pkg::status_t                status_reg, status_next;
    logic                            rd_sel_reg, rd_sel_next;

    logic [SW-1:0]                   sum_hc, sum_r, tail_s, right_s;
    logic [IW-1:0]                   head_dec, head_inc;
    logic                            is_push, right_end, full, empty;
    logic                            ram_we, ram_re;
    logic [IW-1:0]                   ram_addr;
    logic [bdq_pkg::DATA_W-1:0]      ram_rdata;

    always_comb
    begin
        sum_hc    = SW'(head_reg) + SW'(count_reg);
        sum_r     = sum_hc - SW'(1);
        tail_s    = (sum_hc >= DEPTH_S) ? (sum_hc - DEPTH_S) : sum_hc;
        right_s   = (sum_r >= DEPTH_S) ? (sum_r - DEPTH_S) : sum_r;
        head_dec  = (head_reg == '0) ? LAST_I : (head_reg - IW'(1));
        head_inc  = (head_reg == LAST_I) ? '0 : (head_reg + IW'(1));
        is_push   = op_reg inside {bdq_pkg::OP_PUSH_R, bdq_pkg::OP_PUSH_L};
        right_end = ~op_reg[0];
        full      = (count_reg == DEPTH_C);
        empty     = (count_reg == '0);

        head_next   = head_reg;
        count_next  = count_reg;
        status_next = status_reg;
        rd_sel_next = rd_sel_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_addr    = right_end ? IW'(right_s) : head_reg;

        if (cmd.exec)
        begin
            status_next = bdq_pkg::ST_OK;
            rd_sel_next = 1'b0;
            if (is_push)
            begin
                if (full)
                begin
                    status_next = bdq_pkg::ST_FULL;
                end
                else
                begin
                    ram_we     = 1'b1;
                    count_next = count_reg + CW'(1);
                    if (right_end)
                    begin
                        ram_addr = IW'(tail_s);
                    end
                    else
                    begin
                        ram_addr  = head_dec;
                        head_next = head_dec;
                    end
                end
            end
            else if (empty)
            begin
                status_next = bdq_pkg::ST_EMPTY;
            end
            else
            begin
                case (op_reg)
                    bdq_pkg::OP_POP_R, bdq_pkg::OP_POP_L,
                    bdq_pkg::OP_PEEK_R, bdq_pkg::OP_PEEK_L:
                    begin
                        ram_re      = 1'b1;
                        rd_sel_next = 1'b1;
                    end
                    default:
                    begin
                        ram_re = 1'b0;
                    end
                endcase
                // pop and drop remove the end entry
                if (op_reg inside {bdq_pkg::OP_POP_R, bdq_pkg::OP_POP_L,
                                   bdq_pkg::OP_DROP_R, bdq_pkg::OP_DROP_L})
                begin
                    count_next = count_reg - CW'(1);
                    if (!right_end)
                    begin
                        head_next = head_inc;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= bdq_pkg::op_t'(op);
            value_reg <= push_value;
        end
        status_reg <= status_next;
        rd_sel_reg <= rd_sel_next;
    end

    bdq_ram #(
        .WIDTH (bdq_pkg::DATA_W),
        .DEPTH (DEPTH),
        .AW    (IW)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (value_reg),
        .rdata (ram_rdata)
    );

    // RAM read data holds until the next read, so it is stable while responding
    assign read_value = rd_sel_reg ? ram_rdata : '0;
    assign status     = status_reg;
    assign occupancy  = bdq_pkg::OCC_W'(count_reg);

endmodule

`default_nettype wire

// File: design/bounded_deque_unit.sv
// bounded_deque_unit: top level of the bounded double-ended queue.
// Depends on bdq_pkg, bdq_ctrl, bdq_dpath (and bdq_ram below it).
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake            Payload
// -------   ------------------   -------------------------------------
// request   in_valid / in_ready  op[2:0], push_value[31:0] signed
// result    out_valid/out_ready  read_value[31:0] signed, status[1:0],
//                                occupancy[3:0]
//
// One item is handled at a time: accept, execute against the
// single-port entry RAM, then the result is held on the outputs.
// An item passes through the accept, execute and respond states in turn;
// its result is offered only in the respond state, after execute.
// The RAM's registered read sets the execute-to-result step.
// A stalled result (out_ready low) holds everything; in_ready stays low.
// rst_n clears head pointer, count and sequencer; the store needs no clear.

module bounded_deque_unit #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [bdq_pkg::OP_W-1:0]           op,
    input  wire logic signed [bdq_pkg::DATA_W-1:0]  push_value,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [bdq_pkg::DATA_W-1:0]       read_value,
    output logic [bdq_pkg::STATUS_W-1:0]            status,
    output logic [bdq_pkg::OCC_W-1:0]               occupancy
);

    bdq_pkg::bdq_cmd_t cmd;

    bdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    bdq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .op         (op),
        .push_value (push_value),
        .read_value (read_value),
        .status     (status),
        .occupancy  (occupancy)
    );

endmodule

`default_nettype wire

// File: verif/tb_bounded_deque_unit.sv
// tb_bounded_deque_unit: self-checking testbench for the bounded deque block.
// Directed table then biased random requests, checked against a local deque predictor.
// Depends on bdq_pkg and bounded_deque_unit.
`timescale 1ns / 1ps

module tb_bounded_deque_unit;

    localparam int DEPTH          = bdq_pkg::DEPTH_DEF;
    localparam int IDLE_LIMIT     = 5000;  // cycles with no handshake before giving up
    localparam int DRAIN_CYCLES   = 12;    // idle wait after the last pass, before the verdict
    localparam int ITEMS_PER_PASS = 550;   // random requests in each of the three passes

    // expected fields of one result item
    typedef struct {
        logic signed [bdq_pkg::DATA_W-1:0] read_value;
        bdq_pkg::status_t                  status;
        logic [bdq_pkg::OCC_W-1:0]         occupancy;
    } deque_result_t;

    // one row of the directed table; pinned rows carry a hand-written answer
    typedef struct {
        bdq_pkg::op_t                      code;
        logic signed [bdq_pkg::DATA_W-1:0] value;
        bit                                pinned;
        logic signed [bdq_pkg::DATA_W-1:0] read_value;
        bdq_pkg::status_t                  status;
        logic [bdq_pkg::OCC_W-1:0]         occupancy;
    } stim_row_t;

    // DUT ports; the inputs driven here are known from time zero
    logic                                clk        = 1'b0;
    logic                                rst_n      = 1'b0;
    logic                                in_valid   = 1'b0;
    logic                                in_ready;
    logic [bdq_pkg::OP_W-1:0]            op         = '0;
    logic signed [bdq_pkg::DATA_W-1:0]   push_value = '0;
    logic                                out_valid;
    logic                                out_ready  = 1'b0;
    logic signed [bdq_pkg::DATA_W-1:0]   read_value;
    logic [bdq_pkg::STATUS_W-1:0]        status;
    logic [bdq_pkg::OCC_W-1:0]           occupancy;

    // pinned answer travels with the item so the monitor can pick it up on acceptance
    logic                                pin_en     = 1'b0;
    deque_result_t                       pin_result = '{'0, bdq_pkg::ST_OK, '0};

    int send_idle_pct  = 8;
    int recv_stall_pct = 57;
    int error_count    = 0;
    int idle_cycles    = 0;

    // predictor state: circular store, left-end pointer and fill count
    logic signed [bdq_pkg::DATA_W-1:0]   model_slots [DEPTH];
    int                                  model_head  = 0;
    int                                  model_count = 0;

    deque_result_t                       pending_results [$];

    stim_row_t directed_rows [24] = '{
        // every non-push operation on the empty deque after reset
        '{bdq_pkg::OP_POP_R,  32'sd0,  1'b1, 32'sd0, bdq_pkg::ST_EMPTY, 4'd0},
        '{bdq_pkg::OP_POP_L,  32'sd0,  1'b1, 32'sd0, bdq_pkg::ST_EMPTY, 4'd0},
        '{bdq_pkg::OP_PEEK_R, 32'sd0,  1'b1, 32'sd0, bdq_pkg::ST_EMPTY, 4'd0},
        '{bdq_pkg::OP_PEEK_L, -32'sd1, 1'b1, 32'sd0, bdq_pkg::ST_EMPTY, 4'd0},
        '{bdq_pkg::OP_DROP_R, 32'sd0,  1'b1, 32'sd0, bdq_pkg::ST_EMPTY, 4'd0},
        '{bdq_pkg::OP_DROP_L, 32'sd0,  1'b1, 32'sd0, bdq_pkg::ST_EMPTY, 4'd0},
        // extremes on both ends; left push from head zero wraps the pointer
        '{bdq_pkg::OP_PUSH_R, 32'sh7FFF_FFFF, 1'b1, 32'sd0, bdq_pkg::ST_OK, 4'd1},
        '{bdq_pkg::OP_PUSH_L, 32'sh8000_0000, 1'b1, 32'sd0, bdq_pkg::ST_OK, 4'd2},
        '{bdq_pkg::OP_PEEK_R, 32'sd0, 1'b1, 32'sh7FFF_FFFF, bdq_pkg::ST_OK, 4'd2},
        '{bdq_pkg::OP_PEEK_L, 32'sd0, 1'b1, 32'sh8000_0000, bdq_pkg::ST_OK, 4'd2},
        // fill to capacity
        '{bdq_pkg::OP_PUSH_L, -32'sd1,        1'b0, 32'sd0, bdq_pkg::ST_OK, 4'd0},
        '{bdq_pkg::OP_PUSH_R, 32'sd0,         1'b0, 32'sd0, bdq_pkg::ST_OK, 4'd0},
        '{bdq_pkg::OP_PUSH_R, 32'sh5555_5555, 1'b0, 32'sd0, bdq_pkg::ST_OK, 4'd0},
        '{bdq_pkg::OP_PUSH_L, 32'shAAAA_AAAA, 1'b0, 32'sd0, bdq_pkg::ST_OK, 4'd0},
        '{bdq_pkg::OP_PUSH_R, 32'sd1,         1'b0, 32'sd0, bdq_pkg::ST_OK, 4'd0},
        '{bdq_pkg::OP_PUSH_L, 32'sh1234_5678, 1'b0, 32'sd0, bdq_pkg::ST_OK, 4'd0},
        // pushes rejected when full
        '{bdq_pkg::OP_PUSH_R, 32'sh0F0F_0F0F, 1'b1, 32'sd0, bdq_pkg::ST_FULL, 4'd8},
        '{bdq_pkg::OP_PUSH_L, 32'shF0F0_F0F0, 1'b1, 32'sd0, bdq_pkg::ST_FULL, 4'd8},
        // removal from both ends; drops read nothing
        '{bdq_pkg::OP_POP_R,  32'sd0, 1'b0, 32'sd0, bdq_pkg::ST_OK, 4'd0},
        '{bdq_pkg::OP_POP_L,  32'sd0, 1'b0, 32'sd0, bdq_pkg::ST_OK, 4'd0},
        '{bdq_pkg::OP_DROP_R, 32'sd0, 1'b1, 32'sd0, bdq_pkg::ST_OK, 4'd5},
        '{bdq_pkg::OP_DROP_L, 32'sd0, 1'b1, 32'sd0, bdq_pkg::ST_OK, 4'd4},
        '{bdq_pkg::OP_PEEK_R, 32'sd0, 1'b0, 32'sd0, bdq_pkg::ST_OK, 4'd0},
        '{bdq_pkg::OP_PEEK_L, 32'sd0, 1'b0, 32'sd0, bdq_pkg::ST_OK, 4'd0}
    };

    bounded_deque_unit #(
        .DEPTH(DEPTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .push_value (push_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_value (read_value),
        .status     (status),
        .occupancy  (occupancy)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one request to the predictor state and return the result it causes.
    function automatic deque_result_t apply_deque_request(
        bdq_pkg::op_t code, logic signed [bdq_pkg::DATA_W-1:0] val);
        deque_result_t res;
        int            slot;
        bit            at_right;
        res      = '{'0, bdq_pkg::ST_OK, '0};
        at_right = (code == bdq_pkg::OP_PUSH_R || code == bdq_pkg::OP_POP_R ||
                    code == bdq_pkg::OP_PEEK_R || code == bdq_pkg::OP_DROP_R);
        if (code == bdq_pkg::OP_PUSH_R || code == bdq_pkg::OP_PUSH_L)
        begin
            if (model_count >= DEPTH)
                res.status = bdq_pkg::ST_FULL;
            else if (at_right)
            begin
                model_slots[(model_head + model_count) % DEPTH] = val;
                model_count++;
            end
            else
            begin
                model_head = (model_head == 0) ? DEPTH - 1 : model_head - 1;
                model_slots[model_head] = val;
                model_count++;
            end
        end
        else if (model_count == 0)
            res.status = bdq_pkg::ST_EMPTY;
        else
        begin
            slot = at_right ? (model_head + model_count - 1) % DEPTH : model_head;
            if (code == bdq_pkg::OP_POP_R || code == bdq_pkg::OP_POP_L ||
                code == bdq_pkg::OP_PEEK_R || code == bdq_pkg::OP_PEEK_L)
                res.read_value = model_slots[slot];
            if (code != bdq_pkg::OP_PEEK_R && code != bdq_pkg::OP_PEEK_L)
            begin
                if (!at_right)
                    model_head = (model_head + 1) % DEPTH;
                model_count--;
            end
        end
        res.occupancy = model_count[bdq_pkg::OCC_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [bdq_pkg::DATA_W-1:0] got,
                                   logic [bdq_pkg::DATA_W-1:0] want);
        $display("%0t ns: MISMATCH %s got 0x%08h want 0x%08h", $time, what, got, want);
        error_count++;
    endtask

    // Present one request, with random sender gaps, and hold it until accepted.
    task automatic send_request(bdq_pkg::op_t code,
                                logic signed [bdq_pkg::DATA_W-1:0] val, bit pinned,
                                deque_result_t pinned_res);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        op         <= code;
        push_value <= val;
        pin_en     <= pinned;
        pin_result <= pinned_res;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Sender holds off until every outstanding result has come back.
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // receiver back-pressure
    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // Monitor: sample pre-edge values, check results, predict on accepted requests.
    always @(posedge clk)
    begin
        deque_result_t want;
        deque_result_t pred;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("unexpected result item", read_value, '0);
                else
                begin
                    want = pending_results.pop_front();
                    if (read_value !== want.read_value)
                        report_mismatch("read_value", read_value, want.read_value);
                    if (status !== want.status)
                        report_mismatch("status", bdq_pkg::DATA_W'(status),
                                        bdq_pkg::DATA_W'(want.status));
                    if (occupancy !== want.occupancy)
                        report_mismatch("occupancy", bdq_pkg::DATA_W'(occupancy),
                                        bdq_pkg::DATA_W'(want.occupancy));
                end
            end
            if (in_valid && in_ready)
            begin
                pred = apply_deque_request(bdq_pkg::op_t'(op), push_value);
                pending_results.push_back(pin_en ? pin_result : pred);
            end
        end
    end

    // Watchdog: too long without any handshake means the block is stuck.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin : stimulus_main
        int                         pass_idx;
        int                         item_idx;
        int                         push_pct;
        int                         pick;
        bdq_pkg::op_t               code;
        logic [bdq_pkg::DATA_W-1:0] val;
        deque_result_t              pinned_res;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, sender 8% idle, receiver 57% stalled
        foreach (directed_rows[i])
        begin
            pinned_res = '{directed_rows[i].read_value, directed_rows[i].status,
                           directed_rows[i].occupancy};
            send_request(directed_rows[i].code, directed_rows[i].value,
                         directed_rows[i].pinned, pinned_res);
        end
        wait_results_drained();

        for (pass_idx = 0; pass_idx < 3; pass_idx++)
        begin
            case (pass_idx)
                0:
                begin
                    send_idle_pct  = 8;
                    recv_stall_pct = 57;
                end
                1:
                begin
                    send_idle_pct  = 57;
                    recv_stall_pct = 8;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            push_pct = 45;
            for (item_idx = 0; item_idx < ITEMS_PER_PASS; item_idx++)
            begin
                // runs of fill-heavy, drain-heavy or balanced traffic hit both bounds often
                if (item_idx % 40 == 0)
                begin
                    case ($urandom_range(0, 2))
                        0:       push_pct = 75;
                        1:       push_pct = 20;
                        default: push_pct = 45;
                    endcase
                end
                pick = $urandom_range(0, 99);
                if (pick < push_pct)
                    code = $urandom_range(0, 1) ? bdq_pkg::OP_PUSH_L : bdq_pkg::OP_PUSH_R;
                else if (pick < push_pct + 15)
                    code = $urandom_range(0, 1) ? bdq_pkg::OP_PEEK_L : bdq_pkg::OP_PEEK_R;
                else
                begin
                    case ($urandom_range(0, 3))
                        0:       code = bdq_pkg::OP_POP_R;
                        1:       code = bdq_pkg::OP_POP_L;
                        2:       code = bdq_pkg::OP_DROP_R;
                        default: code = bdq_pkg::OP_DROP_L;
                    endcase
                end
                case ($urandom_range(0, 7))
                    0:       val = 32'h7FFF_FFFF;
                    1:       val = 32'h8000_0000;
                    2:       val = $urandom_range(0, 15);
                    3:       val = 32'hFFFF_FFFF;
                    default: val = $urandom;
                endcase
                send_request(code, val, 1'b0, '{'0, bdq_pkg::ST_OK, '0});
            end
            wait_results_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
